// ----- hw/rtl/animation_frame_wrap_defines.svh -----
// ----------------------------------------------------------------------------
// animation_frame_wrap_defines.svh
// Assertion macros shared by the animation frame wrap checker.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_WRAP_DEFINES_SVH
`define ANIMATION_FRAME_WRAP_DEFINES_SVH

// Concurrent property, sampled on the rising edge, off while reset is low
`define AFW_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Expression that must never be true outside reset
`define AFW_NEVER(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/afw_pkg.sv -----
// ----------------------------------------------------------------------------
// afw_pkg
// Types and constants of the animation frame wrap block.
// ----------------------------------------------------------------------------
`default_nettype none

package afw_pkg;

	// Wrap modes; code 7 advances the frame with no wrap rule
	typedef enum logic [2:0] {
		MODE_MANUAL    = 3'd0,
		MODE_LOOP      = 3'd1,
		MODE_ONCE      = 3'd2,
		MODE_PINGPONG  = 3'd3,
		MODE_CLAMP     = 3'd4,
		MODE_LOOP_BACK = 3'd5,
		MODE_ONCE_BACK = 3'd6
	} wrap_mode_t;

	// Register index, byte address divided by four
	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_MODE   = 3'd1,
		REG_COUNT  = 3'd2,
		REG_FPS    = 3'd3,
		REG_MULT   = 3'd4,
		REG_TARGET = 3'd5
	} reg_idx_t;

	localparam int DELTA_W = 45;
	localparam logic [DELTA_W-1:0] DELTA_CAP = 45'd1 << 44;

	// Quotient by 1000 of a 54-bit dividend: floor(y * RECIP / 2^64) is exact
	localparam int Y_W = 54;
	localparam logic [127:0] RECIP_FULL = ((128'd1 << 64) + 128'd999) / 128'd1000;
	localparam logic [54:0] RECIP = RECIP_FULL[54:0];

	localparam logic signed [15:0] DIR_ONE = 16'sd256;
	localparam logic [15:0] DIR_MIN = 16'h8000;
	localparam logic [15:0] DIR_MAX = 16'h7FFF;

	// Edges from an accepted start to the edge that takes the result
	localparam int LATENCY = 11;

	typedef struct packed {
		logic               enable;
		logic [2:0]         mode;
		logic [15:0]        count;
		logic [31:0]        fps;
		logic [15:0]        mult;
		logic [31:0]        target;
	} afw_cfg_t;

	// Item leaving the delta pipeline
	typedef struct packed {
		logic               valid;
		logic [31:0]        frame;
		logic [15:0]        dir;
		logic [DELTA_W-1:0] delta;
	} afw_dbeat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/afw_delta.sv -----
// ----------------------------------------------------------------------------
// afw_delta
// Seven-stage pipeline: elapsed time, rate product, division by 1000 and
// scaling of the frame advance magnitude, held at 2^44.
// ----------------------------------------------------------------------------
`default_nettype none

module afw_delta #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [31:0]        stored_frame,
	input  wire logic [15:0]        play_direction,
	input  wire logic [31:0]        last_sync_ms,
	input  wire logic [31:0]        now_ms,
	input  wire afw_pkg::afw_cfg_t  cfg,
	output afw_pkg::afw_dbeat_t     beat
);

	localparam int S = 32 - FRAC_BITS;
	localparam logic [95:0] CAP_LIMIT = 96'd1000 << (44 + S);
	localparam int YW = afw_pkg::Y_W;

	// stage 1
	logic        v_s1;
	logic [31:0] frame_s1;
	logic [15:0] dir_s1;
	logic [15:0] mag_s1;
	logic [31:0] el_s1;
	logic [47:0] fm_s1;
	// stage 2
	logic        v_s2;
	logic [31:0] frame_s2;
	logic [15:0] dir_s2;
	logic [31:0] el_s2;
	logic [62:0] m_s2;
	// stage 3
	logic        v_s3;
	logic [31:0] frame_s3;
	logic [15:0] dir_s3;
	logic [63:0] pl_s3;
	logic [62:0] ph_s3;
	// stage 4
	logic        v_s4;
	logic [31:0] frame_s4;
	logic [15:0] dir_s4;
	logic          cap_s4;
	logic [YW-1:0] y_s4;
	// stage 5
	logic        v_s5;
	logic [31:0] frame_s5;
	logic [15:0] dir_s5;
	logic        cap_s5;
	logic [53:0] hh_s5;
	logic [54:0] hl_s5;
	logic [53:0] lh_s5;
	logic [54:0] ll_s5;
	// stage 6
	logic         v_s6;
	logic [31:0]  frame_s6;
	logic [15:0]  dir_s6;
	logic         cap_s6;
	logic [108:0] t2_s6;
	logic [82:0]  t1_s6;
	// stage 7
	logic                        v_s7;
	logic [31:0]                 frame_s7;
	logic [15:0]                 dir_s7;
	logic [afw_pkg::DELTA_W-1:0] delta_s7;

	logic [15:0]  mag_c;
	logic [47:0]  fm_c;
	logic [63:0]  m_c;
	logic [63:0]  pl_c;
	logic [63:0]  ph_c;
	logic [94:0]  x_c;
	logic [26:0]  yh_c;
	logic [26:0]  yl_c;
	logic [26:0]  rh_c;
	logic [27:0]  rl_c;
	logic [108:0] sum_c;

	assign mag_c = play_direction[15] ? (~play_direction + 16'd1) : play_direction;
	assign fm_c  = {16'd0, cfg.fps} * {32'd0, cfg.mult};
	assign m_c   = {16'd0, fm_s1} * {48'd0, mag_s1};
	assign pl_c  = {32'd0, m_s2[31:0]} * {32'd0, el_s2};
	assign ph_c  = {33'd0, m_s2[62:32]} * {32'd0, el_s2};
	assign x_c   = {ph_s3, 32'd0} + {31'd0, pl_s3};
	assign yh_c  = y_s4[53:27];
	assign yl_c  = y_s4[26:0];
	assign rh_c  = afw_pkg::RECIP[54:28];
	assign rl_c  = afw_pkg::RECIP[27:0];
	assign sum_c = t2_s6 + {26'd0, t1_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		frame_s1 <= stored_frame;
		dir_s1   <= play_direction;
		mag_s1   <= mag_c;
		el_s1    <= now_ms - last_sync_ms;
		fm_s1    <= fm_c;

		frame_s2 <= frame_s1;
		dir_s2   <= dir_s1;
		el_s2    <= el_s1;
		m_s2     <= m_c[62:0];

		frame_s3 <= frame_s2;
		dir_s3   <= dir_s2;
		pl_s3    <= pl_c;
		ph_s3    <= ph_c[62:0];

		// past the cap the quotient is not needed, only the flag
		frame_s4 <= frame_s3;
		dir_s4   <= dir_s3;
		cap_s4   <= {1'b0, x_c} >= CAP_LIMIT;
		y_s4     <= x_c[S +: YW];

		frame_s5 <= frame_s4;
		dir_s5   <= dir_s4;
		cap_s5   <= cap_s4;
		hh_s5    <= {27'd0, yh_c} * {27'd0, rh_c};
		hl_s5    <= {28'd0, yh_c} * {27'd0, rl_c};
		lh_s5    <= {27'd0, yl_c} * {27'd0, rh_c};
		ll_s5    <= {28'd0, yl_c} * {27'd0, rl_c};

		frame_s6 <= frame_s5;
		dir_s6   <= dir_s5;
		cap_s6   <= cap_s5;
		t2_s6    <= {hh_s5, ll_s5};
		t1_s6    <= {1'b0, hl_s5, 27'd0} + {1'b0, lh_s5, 28'd0};

		frame_s7 <= frame_s6;
		dir_s7   <= dir_s6;
		delta_s7 <= cap_s6 ? afw_pkg::DELTA_CAP : sum_c[108:64];
	end

	assign beat.valid = v_s7;
	assign beat.frame = frame_s7;
	assign beat.dir   = dir_s7;
	assign beat.delta = delta_s7;

endmodule

`default_nettype wire

// ----- hw/rtl/afw_wrap.sv -----
// ----------------------------------------------------------------------------
// afw_wrap
// Frame advance, wrap rule per mode, direction reversal and saturation,
// in three stages followed by the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module afw_wrap #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire afw_pkg::afw_cfg_t  cfg,
	input  wire afw_pkg::afw_dbeat_t beat,
	output logic                    done,
	output logic [31:0]             current_frame,
	output logic [15:0]             new_direction
);

	localparam int W = 48;

	logic signed [W-1:0] last_c;
	logic signed [W-1:0] target_c;
	logic signed [W-1:0] dext_c;
	logic signed [W-1:0] fext_c;
	logic [16:0]         cnt_m1_c;

	// stage 8
	logic                v_s8;
	logic [31:0]         fr0_s8;
	logic [15:0]         dir_s8;
	logic signed [W-1:0] f_s8;
	// stage 9
	logic                v_s9;
	logic [31:0]         fr0_s9;
	logic [15:0]         dir_s9;
	logic signed [W-1:0] f_s9;
	logic                ge_s9;
	logic                neg_s9;
	logic                gt_t_s9;
	logic                lt_t_s9;
	logic signed [W-1:0] sub_s9;
	logic signed [W-1:0] add_s9;
	logic signed [W-1:0] ref_s9;
	logic signed [W-1:0] inv_s9;
	// stage 10
	logic                v_s10;
	logic [15:0]         dir_s10;
	logic                flip_s10;
	logic signed [W-1:0] f_s10;
	// result
	logic                done_s11;
	logic [31:0]         frame_s11;
	logic [15:0]         ndir_s11;

	logic signed [W-1:0] fsel_c;
	logic                flip_c;
	logic                fwd_c;
	logic                in_range_c;

	assign cnt_m1_c = {1'b0, cfg.count} - 17'd1;
	assign last_c   = $signed({{(W-17){cnt_m1_c[16]}}, cnt_m1_c}) <<< FRAC_BITS;
	assign target_c = $signed({{(W-32){cfg.target[31]}}, cfg.target});
	assign dext_c   = $signed({{(W-afw_pkg::DELTA_W){1'b0}}, beat.delta});
	assign fext_c   = $signed({{(W-32){beat.frame[31]}}, beat.frame});
	assign fwd_c    = $signed(dir_s9) >= afw_pkg::DIR_ONE;

	always_comb begin
		fsel_c = f_s9;
		flip_c = 1'b0;
		if (!cfg.enable) begin
			fsel_c = '0;
		end else begin
			case (cfg.mode)
				afw_pkg::MODE_MANUAL: begin
					fsel_c = $signed({{(W-32){fr0_s9[31]}}, fr0_s9});
				end
				afw_pkg::MODE_ONCE: begin
					if (ge_s9) fsel_c = last_c;
				end
				afw_pkg::MODE_LOOP: begin
					if (ge_s9) fsel_c = (sub_s9 >= last_c) ? '0 : sub_s9;
				end
				afw_pkg::MODE_ONCE_BACK: begin
					if (neg_s9) fsel_c = '0;
				end
				afw_pkg::MODE_LOOP_BACK: begin
					if (neg_s9) fsel_c = (add_s9 < 0) ? last_c : add_s9;
				end
				afw_pkg::MODE_PINGPONG: begin
					// reflect off the end crossed; reset if still out going backward
					if (fwd_c) begin
						if (ge_s9) begin
							fsel_c = (ref_s9 >= last_c) ? last_c : ref_s9;
							flip_c = 1'b1;
						end
					end else if (neg_s9) begin
						fsel_c = (inv_s9 >= last_c) ? '0 : inv_s9;
						flip_c = 1'b1;
					end
				end
				afw_pkg::MODE_CLAMP: begin
					if ($signed(dir_s9) > 0) begin
						if (gt_t_s9) fsel_c = target_c;
					end else begin
						if (lt_t_s9) fsel_c = target_c;
					end
				end
				default: begin
					fsel_c = f_s9;
				end
			endcase
		end
	end

	assign in_range_c = (&f_s10[W-1:31]) || !(|f_s10[W-1:31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			done_s11 <= 1'b0;
		end else begin
			v_s8     <= beat.valid;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			done_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		fr0_s8 <= beat.frame;
		dir_s8 <= beat.dir;
		f_s8   <= fext_c + (beat.dir[15] ? -dext_c : dext_c);

		fr0_s9  <= fr0_s8;
		dir_s9  <= dir_s8;
		f_s9    <= f_s8;
		ge_s9   <= f_s8 >= last_c;
		neg_s9  <= f_s8 < 0;
		gt_t_s9 <= f_s8 > target_c;
		lt_t_s9 <= f_s8 < target_c;
		sub_s9  <= f_s8 - last_c;
		add_s9  <= f_s8 + last_c;
		ref_s9  <= (last_c <<< 1) - f_s8;
		inv_s9  <= -f_s8;

		dir_s10  <= dir_s9;
		flip_s10 <= flip_c;
		f_s10    <= fsel_c;

		// saturate to the 32-bit frame range
		if (in_range_c) begin
			frame_s11 <= f_s10[31:0];
		end else begin
			frame_s11 <= f_s10[W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if (!flip_s10) begin
			ndir_s11 <= dir_s10;
		end else if (dir_s10 == afw_pkg::DIR_MIN) begin
			ndir_s11 <= afw_pkg::DIR_MAX;
		end else begin
			ndir_s11 <= ~dir_s10 + 16'd1;
		end
	end

	assign done          = done_s11;
	assign current_frame = frame_s11;
	assign new_direction = ndir_s11;

endmodule

`default_nettype wire

// ----- hw/rtl/animation_frame_wrap.sv -----
// ----------------------------------------------------------------------------
// animation_frame_wrap
// Keyframe position from elapsed time with manual, loop, once, ping-pong,
// clamp-to-frame and backward loop/once wrap modes; APB-style register port.
// ----------------------------------------------------------------------------
// A query is taken on any cycle with start high; busy never rises, so one
// query per clock is sustained. Its result appears on current_frame and
// new_direction with done high for a single cycle, after the query has
// passed the pipeline: the rate multiply chain, the reciprocal-multiply
// division by 1000, the wrap stages and the result register. Results come
// out in query order and cannot be held off, so the receiver must take
// every done beat. Write registers only while no query is in flight.
`default_nettype none

module animation_frame_wrap #(
	parameter int FRAME_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] stored_frame,
	input  wire logic [15:0] play_direction,
	input  wire logic [31:0] last_sync_ms,
	input  wire logic [31:0] now_ms,
	output logic             done,
	output logic [31:0]      current_frame,
	output logic [15:0]      new_direction,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        enable_q;
	logic [2:0]  mode_q;
	logic [15:0] count_q;
	logic [31:0] fps_q;
	logic [15:0] mult_q;
	logic [31:0] target_q;

	logic                wr_en;
	afw_pkg::afw_cfg_t   cfg;
	afw_pkg::afw_dbeat_t dbeat;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			mode_q   <= afw_pkg::MODE_MANUAL;
			count_q  <= 16'd1;
			fps_q    <= 32'h001E_0000;
			mult_q   <= 16'h0100;
			target_q <= 32'd0;
		end else if (wr_en) begin
			case (paddr[4:2])
				afw_pkg::REG_ENABLE: enable_q <= pwdata[0];
				afw_pkg::REG_MODE:   mode_q   <= pwdata[2:0];
				afw_pkg::REG_COUNT:  count_q  <= pwdata[15:0];
				afw_pkg::REG_FPS:    fps_q    <= pwdata;
				afw_pkg::REG_MULT:   mult_q   <= pwdata[15:0];
				afw_pkg::REG_TARGET: target_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			afw_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			afw_pkg::REG_MODE:   prdata = {29'd0, mode_q};
			afw_pkg::REG_COUNT:  prdata = {16'd0, count_q};
			afw_pkg::REG_FPS:    prdata = fps_q;
			afw_pkg::REG_MULT:   prdata = {16'd0, mult_q};
			afw_pkg::REG_TARGET: prdata = target_q;
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg.enable = enable_q;
	assign cfg.mode   = mode_q;
	assign cfg.count  = count_q;
	assign cfg.fps    = fps_q;
	assign cfg.mult   = mult_q;
	assign cfg.target = target_q;

	afw_delta #(
		.FRAC_BITS(FRAME_FRAC_BITS)
	) u_delta (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start && !busy),
		.stored_frame  (stored_frame),
		.play_direction(play_direction),
		.last_sync_ms  (last_sync_ms),
		.now_ms        (now_ms),
		.cfg           (cfg),
		.beat          (dbeat)
	);

	afw_wrap #(
		.FRAC_BITS(FRAME_FRAC_BITS)
	) u_wrap (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.beat         (dbeat),
		.done         (done),
		.current_frame(current_frame),
		.new_direction(new_direction)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/afw_checker.sv -----
// ----------------------------------------------------------------------------
// afw_checker
// Port-level checks of the animation frame wrap block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "animation_frame_wrap_defines.svh"

module afw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [15:0] play_direction,
	input wire logic        done,
	input wire logic [15:0] new_direction
);

	localparam int Lat = afw_pkg::LATENCY;

	`AFW_NEVER(a_never_busy, clk, arst_n, busy, "busy rose")
	`AFW_ASSERT(a_start_done, clk, arst_n, start && !busy |-> ##Lat done, "done beat missing")
	`AFW_ASSERT(a_done_start, clk, arst_n, done |-> $past(start && !busy, Lat), "done without a query")
	`AFW_ASSERT(a_dir_kept, clk, arst_n, done |-> (new_direction == $past(play_direction, Lat)) || (new_direction == -$past(play_direction, Lat)) || (new_direction == 16'h7FFF && $past(play_direction, Lat) == 16'h8000), "direction neither kept nor reversed")

endmodule

bind animation_frame_wrap afw_checker u_afw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.play_direction(play_direction),
	.done          (done),
	.new_direction (new_direction)
);

`default_nettype wire
